// ----- design/bitfield_pixel_unpacker_assert.svh -----
// Assertion macros used by the pixel unpacker queue.
`ifndef BITFIELD_PIXEL_UNPACKER_ASSERT_SVH
`define BITFIELD_PIXEL_UNPACKER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpu assertion failed");
// Next-cycle implication.
`define BPU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpu assertion failed");
`else
`define BPU_ASSERT_IMP(label, ante, cons)
`define BPU_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- design/bpu_pkg.sv -----
// Types, constants and helper functions of the bitfield pixel unpacker.
`default_nettype none
package bpu_pkg;
	localparam int NumChan = 4;
	localparam int QueueDepth = 4;
	localparam int QueuePtrBits = $clog2(QueueDepth);
	localparam int QueueCountBits = $clog2(QueueDepth + 1);
	localparam int RemBits = 42;
	localparam int DenBits = 33;
	localparam int QuoBits = 9;

	localparam logic [2:0] RegImageWidth = 3'd0;
	localparam logic [2:0] RegImageHeight = 3'd1;
	localparam logic [2:0] RegBytesPerPixel = 3'd2;
	localparam logic [2:0] RegRedMask = 3'd3;
	localparam logic [2:0] RegGreenMask = 3'd4;
	localparam logic [2:0] RegBlueMask = 3'd5;
	localparam logic [2:0] RegAlphaMask = 3'd6;

	localparam logic [31:0] ResetRedMask = 32'h00FF_0000;
	localparam logic [31:0] ResetGreenMask = 32'h0000_FF00;
	localparam logic [31:0] ResetBlueMask = 32'h0000_00FF;
	localparam logic [31:0] ResetAlphaMask = 32'h0000_0000;

	typedef struct packed {
		logic [31:0] word;
		logic        row_end;
		logic        image_end;
	} entry_t;

	typedef struct packed {
		logic [31:0] mask;
		logic [4:0]  shift;
		logic [5:0]  pop;
	} chan_cfg_t;

	function automatic logic [4:0] lowest_bit(input logic [31:0] m);
		logic [4:0] res;
		res = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (m[b]) res = 5'(b);
		end
		return res;
	endfunction

	function automatic logic [5:0] pop_count(input logic [31:0] m);
		logic [5:0] res;
		res = 6'd0;
		for (int b = 0; b < 32; b++) begin
			res = res + 6'(m[b]);
		end
		return res;
	endfunction

	function automatic chan_cfg_t derive(input logic [31:0] m);
		chan_cfg_t c;
		c.mask = m;
		c.shift = lowest_bit(m);
		c.pop = pop_count(m);
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- design/bpu_front.sv -----
// Byte gatherer: builds pixel words, tracks columns, rows and row padding.
`default_nettype none
module bpu_front #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          data_byte,
	input  wire logic [15:0]         image_width,
	input  wire logic [15:0]         image_height,
	input  wire logic [2:0]          bytes_per_pixel,
	input  wire logic                q_full,
	output logic                     push,
	output bpu_pkg::entry_t          push_entry
);
	localparam logic [32:0] LimTop = 33'(1) << COORD_BITS;

	logic [31:0]           word_q;
	logic [1:0]            idx_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [1:0]            pad_q;

	logic        accept;
	logic [2:0]  bpp_eff;
	logic [31:0] word_next;
	logic        last_byte;
	logic [32:0] width_lim;
	logic [32:0] height_lim;
	logic        col_end;
	logic        row_last;
	logic [3:0]  row_prod;
	logic [1:0]  pad_next;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	always_comb begin
		if (bytes_per_pixel == 3'd0) bpp_eff = 3'd1;
		else if (bytes_per_pixel > 3'd4) bpp_eff = 3'd4;
		else bpp_eff = bytes_per_pixel;
	end

	always_comb begin
		if (image_width == 16'd0) width_lim = 33'd1;
		else if (33'(image_width) > LimTop) width_lim = LimTop;
		else width_lim = 33'(image_width);
		if (image_height == 16'd0) height_lim = 33'd1;
		else if (33'(image_height) > LimTop) height_lim = LimTop;
		else height_lim = 33'(image_height);
	end

	assign word_next = ((idx_q == 2'd0) ? 32'd0 : word_q) |
		(32'(data_byte) << {idx_q, 3'b000});
	assign last_byte = ({1'b0, idx_q} + 3'd1) >= bpp_eff;
	assign col_end = (33'(col_q) + 33'd1) >= width_lim;
	assign row_last = (33'(row_q) + 33'd1) >= height_lim;
	assign row_prod = 4'(image_width[1:0]) * 4'(bpp_eff[1:0]);
	assign pad_next = 2'd0 - row_prod[1:0];

	assign push = accept && (pad_q == 2'd0) && last_byte;
	assign push_entry.word = word_next;
	assign push_entry.row_end = col_end;
	assign push_entry.image_end = col_end && row_last;

	always_ff @(posedge clk) begin
		if (accept && pad_q == 2'd0) word_q <= word_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			col_q <= '0;
			row_q <= '0;
			pad_q <= '0;
		end else if (accept) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!last_byte) begin
				idx_q <= idx_q + 2'd1;
			end else begin
				idx_q <= '0;
				if (col_end) begin
					col_q <= '0;
					pad_q <= pad_next;
					if (row_last) row_q <= '0;
					else row_q <= row_q + COORD_BITS'(1);
				end else begin
					col_q <= col_q + COORD_BITS'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/bpu_queue.sv -----
// Short word queue between the byte gatherer and the channel scaler.
`default_nettype none
`include "bitfield_pixel_unpacker_assert.svh"
module bpu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bpu_pkg::entry_t push_entry,
	input  wire logic            pop,
	output bpu_pkg::entry_t      head,
	output logic                 full,
	output logic                 empty
);
	bpu_pkg::entry_t mem_q [bpu_pkg::QueueDepth];
	logic [bpu_pkg::QueuePtrBits-1:0]   wr_ptr_q;
	logic [bpu_pkg::QueuePtrBits-1:0]   rd_ptr_q;
	logic [bpu_pkg::QueueCountBits-1:0] count_q;

	assign full = count_q == bpu_pkg::QueueCountBits'(bpu_pkg::QueueDepth);
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + bpu_pkg::QueuePtrBits'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + bpu_pkg::QueuePtrBits'(1);
			if (push && !pop) count_q <= count_q + bpu_pkg::QueueCountBits'(1);
			else if (pop && !push) count_q <= count_q - bpu_pkg::QueueCountBits'(1);
		end
	end

	`BPU_ASSERT_IMP(a_no_push_full, push, !full)
	`BPU_ASSERT_IMP(a_no_pop_empty, pop, !empty)
	`BPU_ASSERT_NXT(a_push_fills, push && !pop, !empty)
endmodule
`default_nettype wire

// ----- design/bpu_back.sv -----
// Channel scaler: extracts each masked field and scales it to eight bits.
`default_nettype none
module bpu_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire bpu_pkg::entry_t    head,
	output logic                    pop,
	input  wire bpu_pkg::chan_cfg_t chan_cfg [bpu_pkg::NumChan],
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic [7:0]              alpha,
	output logic                    row_end,
	output logic                    image_end
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic [3:0] step_q;
	logic [31:0] word_q;
	logic row_end_q;
	logic image_end_q;
	logic [31:0] v_q [bpu_pkg::NumChan];
	logic [bpu_pkg::RemBits-1:0] rem_q [bpu_pkg::NumChan];
	logic [bpu_pkg::DenBits-1:0] den_q [bpu_pkg::NumChan];
	logic [bpu_pkg::QuoBits-1:0] quo_q [bpu_pkg::NumChan];
	logic [7:0] res_q [bpu_pkg::NumChan];
	logic out_valid_q;

	logic [32:0] mx_c [bpu_pkg::NumChan];
	logic [bpu_pkg::RemBits-1:0] trial_c [bpu_pkg::NumChan];
	logic [7:0] scaled_c [bpu_pkg::NumChan];
	logic out_free;

	assign pop = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		for (int c = 0; c < bpu_pkg::NumChan; c++) begin
			mx_c[c] = (33'(1) << chan_cfg[c].pop) - 33'd1;
			trial_c[c] = bpu_pkg::RemBits'(den_q[c]) << step_q;
			if (chan_cfg[c].pop == 6'd0) scaled_c[c] = 8'd0;
			else if (quo_q[c][8]) scaled_c[c] = 8'hFF;
			else scaled_c[c] = quo_q[c][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head.word;
			row_end_q <= head.row_end;
			image_end_q <= head.image_end;
		end
		for (int c = 0; c < bpu_pkg::NumChan; c++) begin
			if (state_q == ST_SHIFT) v_q[c] <= (word_q & chan_cfg[c].mask) >> chan_cfg[c].shift;
			if (state_q == ST_MUL) begin
				rem_q[c] <= (bpu_pkg::RemBits'(v_q[c]) * bpu_pkg::RemBits'(510)) +
					bpu_pkg::RemBits'(mx_c[c]);
				den_q[c] <= {mx_c[c][31:0], 1'b0};
				quo_q[c] <= '0;
			end
			if (state_q == ST_DIV && rem_q[c] >= trial_c[c]) begin
				rem_q[c] <= rem_q[c] - trial_c[c];
				quo_q[c][step_q] <= 1'b1;
			end
			if (state_q == ST_HOLD && out_free) res_q[c] <= scaled_c[c];
		end
		if (state_q == ST_HOLD && out_free) begin
			row_end <= row_end_q;
			image_end <= image_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) state_q <= ST_SHIFT;
				end
				ST_SHIFT: state_q <= ST_MUL;
				ST_MUL: begin
					step_q <= 4'd8;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 4'd0) state_q <= ST_HOLD;
					else step_q <= step_q - 4'd1;
				end
				ST_HOLD: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign red = res_q[0];
	assign green = res_q[1];
	assign blue = res_q[2];
	assign alpha = res_q[3];
endmodule
`default_nettype wire

// ----- design/bitfield_pixel_unpacker.sv -----
// Top level of the bitfield pixel unpacker: registers, gatherer, queue, scaler.
// Usage:
//  The input channel (in_valid, in_stall, data_byte) takes one byte of the
//  bitmap pixel array per beat, row padding included. Bytes are gathered
//  little-endian into words of bytes_per_pixel bytes; padding to a four-byte
//  row boundary is swallowed without output.
//  The output channel (out_valid, out_stall) carries one RGBA8888 beat per
//  pixel word, with row_end and image_end flags on the last pixel of a row
//  and of the image.
//  Registers are written through cfg_we / cfg_index / cfg_data while idle.
//  Each pixel word passes from the queue through the scaler states SHIFT,
//  MUL, DIV and HOLD (field extract, one multiply, then a nine-step
//  restoring divide shared by nothing else); the scaler takes the next word
//  only after the last pixel has left HOLD. Bytes enter at one per cycle
//  until the four-entry word queue fills, then in_stall rises.
//  A stalled output beat holds; the scaler waits and the queue keeps filling.
//  Reset clears the stream position and loads the default 32-bit XRGB
//  layout with a width and height of one.
`default_nettype none
module bitfield_pixel_unpacker #(
	parameter int COORD_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             row_end,
	output logic             image_end
);
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  bpp_q;
	logic [31:0] mask_q [bpu_pkg::NumChan];
	bpu_pkg::chan_cfg_t chan_cfg_q [bpu_pkg::NumChan];

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	bpu_pkg::entry_t push_entry;
	bpu_pkg::entry_t head;

	// Register file; writes to an unused index drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd1;
			height_q <= 16'd1;
			bpp_q <= 3'd4;
			mask_q[0] <= bpu_pkg::ResetRedMask;
			mask_q[1] <= bpu_pkg::ResetGreenMask;
			mask_q[2] <= bpu_pkg::ResetBlueMask;
			mask_q[3] <= bpu_pkg::ResetAlphaMask;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpu_pkg::RegImageWidth: width_q <= cfg_data[15:0];
				bpu_pkg::RegImageHeight: height_q <= cfg_data[15:0];
				bpu_pkg::RegBytesPerPixel: bpp_q <= cfg_data[2:0];
				bpu_pkg::RegRedMask: mask_q[0] <= cfg_data;
				bpu_pkg::RegGreenMask: mask_q[1] <= cfg_data;
				bpu_pkg::RegBlueMask: mask_q[2] <= cfg_data;
				bpu_pkg::RegAlphaMask: mask_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derive field shift and width, registered, in the cycle after each mask write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg_q[0] <= bpu_pkg::derive(bpu_pkg::ResetRedMask);
			chan_cfg_q[1] <= bpu_pkg::derive(bpu_pkg::ResetGreenMask);
			chan_cfg_q[2] <= bpu_pkg::derive(bpu_pkg::ResetBlueMask);
			chan_cfg_q[3] <= bpu_pkg::derive(bpu_pkg::ResetAlphaMask);
		end else begin
			for (int c = 0; c < bpu_pkg::NumChan; c++) begin
				chan_cfg_q[c] <= bpu_pkg::derive(mask_q[c]);
			end
		end
	end

	bpu_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.image_width(width_q),
		.image_height(height_q),
		.bytes_per_pixel(bpp_q),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	bpu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	bpu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.chan_cfg(chan_cfg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.row_end(row_end),
		.image_end(image_end)
	);
endmodule
`default_nettype wire

// ----- sim/bitfield_pixel_unpacker_test.sv -----
// Testbench of the bitfield pixel unpacker: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       row_end;
	logic       image_end;
} pixel_t;

class pixel_scoreboard;
	logic [15:0] width_reg, height_reg;
	logic [2:0]  bpp_reg;
	logic [31:0] mask_reg [4];
	logic [31:0] word_acc;
	int unsigned byte_pos, col, row, pad;
	pixel_t      pending_pixels [$];
	int          errors;

	function new();
		width_reg = 16'd1;
		height_reg = 16'd1;
		bpp_reg = 3'd4;
		mask_reg[0] = bpu_pkg::ResetRedMask;
		mask_reg[1] = bpu_pkg::ResetGreenMask;
		mask_reg[2] = bpu_pkg::ResetBlueMask;
		mask_reg[3] = bpu_pkg::ResetAlphaMask;
		word_acc = '0;
		byte_pos = 0;
		col = 0;
		row = 0;
		pad = 0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			bpu_pkg::RegImageWidth: width_reg = val[15:0];
			bpu_pkg::RegImageHeight: height_reg = val[15:0];
			bpu_pkg::RegBytesPerPixel: bpp_reg = val[2:0];
			bpu_pkg::RegRedMask: mask_reg[0] = val;
			bpu_pkg::RegGreenMask: mask_reg[1] = val;
			bpu_pkg::RegBlueMask: mask_reg[2] = val;
			bpu_pkg::RegAlphaMask: mask_reg[3] = val;
			default: ;
		endcase
	endfunction

	// Scale one channel: round(v*255/max), ties up, saturated.
	function logic [7:0] scale_channel(logic [31:0] m, logic [31:0] w);
		int unsigned n, low;
		logic [63:0] v, mx, r;
		n = 0;
		low = 0;
		for (int b = 31; b >= 0; b--) begin
			if (m[b]) begin
				n++;
				low = b;
			end
		end
		if (n == 0) return 8'd0;
		mx = (64'd1 << n) - 64'd1;
		v = 64'((w & m) >> low);
		r = (v * 64'd510 + mx) / (64'd2 * mx);
		return (r > 64'd255) ? 8'd255 : r[7:0];
	endfunction

	function void note_byte(logic [7:0] b);
		int unsigned bpp, w, h;
		pixel_t p;
		if (pad != 0) begin
			pad--;
			return;
		end
		bpp = (bpp_reg == 0) ? 1 : (bpp_reg > 4) ? 4 : bpp_reg;
		if (byte_pos == 0) word_acc = '0;
		word_acc |= 32'(b) << (8 * byte_pos);
		if (byte_pos + 1 < bpp) begin
			byte_pos++;
			return;
		end
		byte_pos = 0;
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		p.row_end = 1'b0;
		p.image_end = 1'b0;
		if (col + 1 >= w) begin
			p.row_end = 1'b1;
			col = 0;
			// Padding follows the raw width register, zero included.
			pad = (4 - ((width_reg * bpp) & 3)) & 3;
			if (row + 1 >= h) begin
				p.image_end = 1'b1;
				row = 0;
			end else row++;
		end else col++;
		p.red = scale_channel(mask_reg[0], word_acc);
		p.green = scale_channel(mask_reg[1], word_acc);
		p.blue = scale_channel(mask_reg[2], word_acc);
		p.alpha = scale_channel(mask_reg[3], word_acc);
		pending_pixels.push_back(p);
	endfunction

	function void check_pixel(pixel_t got);
		pixel_t e;
		if (pending_pixels.size() == 0) begin
			$error("unexpected pixel beat");
			errors++;
			return;
		end
		e = pending_pixels.pop_front();
		if (got.red !== e.red) begin
			$error("red: expected %0d, got %0d", e.red, got.red);
			errors++;
		end
		if (got.green !== e.green) begin
			$error("green: expected %0d, got %0d", e.green, got.green);
			errors++;
		end
		if (got.blue !== e.blue) begin
			$error("blue: expected %0d, got %0d", e.blue, got.blue);
			errors++;
		end
		if (got.alpha !== e.alpha) begin
			$error("alpha: expected %0d, got %0d", e.alpha, got.alpha);
			errors++;
		end
		if (got.row_end !== e.row_end) begin
			$error("row_end: expected %0d, got %0d", e.row_end, got.row_end);
			errors++;
		end
		if (got.image_end !== e.image_end) begin
			$error("image_end: expected %0d, got %0d", e.image_end, got.image_end);
			errors++;
		end
	endfunction
endclass

module bitfield_pixel_unpacker_test;
	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_stall;
	logic [7:0]  data_byte;
	logic        out_valid, out_stall;
	logic [7:0]  red, green, blue, alpha;
	logic        row_end, image_end;

	pixel_scoreboard sb;
	longint cycles;
	// A long hold-off on the output, requested by the stimulus process.
	int hold_request;

	bitfield_pixel_unpacker dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: budget covers the scaling of each pixel plus worst stalls per byte.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("bitfield_pixel_unpacker_test: done, errors");
				$finish;
			end
		end
	end

	// Drop the input, write one register, then idle with the write enable low.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Offer one byte after a random gap, unless no_gap is set, and hold it until taken.
	task automatic send_byte(logic [7:0] b, bit no_gap);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
	endtask

	// Drop the input, wait for every expected pixel, then for stragglers.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_image(int nbytes, bit burst);
		for (int i = 0; i < nbytes; i++) send_byte(8'($urandom), burst);
	endtask

	// Receiver: draw a stall per beat, or hold off for a long stretch on request.
	initial begin
		int stall_len;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				out_stall <= 1'b1;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				stall_len = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
				if (stall_len != 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Check each accepted output beat.
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.red = red;
			got.green = green;
			got.blue = blue;
			got.alpha = alpha;
			got.row_end = row_end;
			got.image_end = image_end;
			sb.check_pixel(got);
		end
	end

	initial begin
		logic [31:0] masks [4];
		int w, h, bpp, nbytes;
		sb = new();
		hold_request = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bpu_pkg::RegImageWidth;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset layout, byte extremes.
		send_byte(8'h00, 0);
		send_byte(8'hFF, 0);
		send_byte(8'hFF, 0);
		send_byte(8'hFF, 0);
		for (int i = 0; i < 4; i++) send_byte(8'hFF, 1);
		drain();

		// Directed: zero, full, scattered masks; 3 bpp with padding, width 3.
		write_reg(bpu_pkg::RegImageWidth, 32'd3);
		write_reg(bpu_pkg::RegImageHeight, 32'd2);
		write_reg(bpu_pkg::RegBytesPerPixel, 32'd3);
		write_reg(bpu_pkg::RegRedMask, 32'hFFFF_FFFF);
		write_reg(bpu_pkg::RegGreenMask, 32'h0080_0001);
		write_reg(bpu_pkg::RegBlueMask, 32'h0000_0000);
		write_reg(bpu_pkg::RegAlphaMask, 32'h8000_0000);
		send_image(2 * 12, 1);
		drain();

		// Directed: out-of-range sizes (zero, 0 and 7 bpp), all-ones then all-zero pixels.
		write_reg(bpu_pkg::RegImageWidth, 32'd0);
		write_reg(bpu_pkg::RegImageHeight, 32'd0);
		write_reg(bpu_pkg::RegBytesPerPixel, 32'd0);
		write_reg(bpu_pkg::RegAlphaMask, 32'h0000_00FF);
		for (int i = 0; i < 8; i++) send_byte(8'hFF, 0);
		drain();
		write_reg(bpu_pkg::RegBytesPerPixel, 32'd7);
		for (int i = 0; i < 8; i++) send_byte(8'h00, 0);
		drain();

		// Maximum width and height: a partial row of a huge image.
		write_reg(bpu_pkg::RegImageWidth, 32'hFFFF);
		write_reg(bpu_pkg::RegImageHeight, 32'hFFFF);
		write_reg(bpu_pkg::RegBytesPerPixel, 32'd1);
		hold_request = 300;
		send_image(40, 1);
		drain();

		// Random phases: small images, random layouts and masks.
		for (int ph = 0; ph < 12; ph++) begin
			w = $urandom_range(1, 7);
			h = $urandom_range(1, 3);
			bpp = $urandom_range(1, 4);
			for (int c = 0; c < 4; c++) begin
				case ($urandom_range(0, 4))
					0: masks[c] = 32'h0;
					1: masks[c] = 32'hFFFF_FFFF;
					2: masks[c] = $urandom;
					default: masks[c] = ((32'd1 << $urandom_range(1, 8)) - 1)
						<< $urandom_range(0, 24);
				endcase
			end
			write_reg(bpu_pkg::RegImageWidth, 32'(w));
			write_reg(bpu_pkg::RegImageHeight, 32'(h));
			write_reg(bpu_pkg::RegBytesPerPixel, 32'(bpp));
			write_reg(bpu_pkg::RegRedMask, masks[0]);
			write_reg(bpu_pkg::RegGreenMask, masks[1]);
			write_reg(bpu_pkg::RegBlueMask, masks[2]);
			write_reg(bpu_pkg::RegAlphaMask, masks[3]);
			nbytes = h * ((w * bpp + 3) / 4 * 4);
			if (ph == 5) hold_request = 200;
			send_image(2 * nbytes, ph == 5);
			drain();
		end

		// Restore the default layout at the end.
		write_reg(bpu_pkg::RegImageWidth, 32'd1);
		write_reg(bpu_pkg::RegImageHeight, 32'd1);
		write_reg(bpu_pkg::RegBytesPerPixel, 32'd4);
		write_reg(bpu_pkg::RegRedMask, bpu_pkg::ResetRedMask);
		write_reg(bpu_pkg::RegGreenMask, bpu_pkg::ResetGreenMask);
		write_reg(bpu_pkg::RegBlueMask, bpu_pkg::ResetBlueMask);
		write_reg(bpu_pkg::RegAlphaMask, bpu_pkg::ResetAlphaMask);
		send_image(8, 0);
		drain();

		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("bitfield_pixel_unpacker_test: done, clean");
		else
			$display("bitfield_pixel_unpacker_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
